### rtl/hsd_pkg.sv
// Shared constants for the Huffman stream decoder: decode phase codes,
// node memory write selects and the tree-end phase rule.
// No dependencies.
`default_nettype none

package hsd_pkg;

    localparam int SYM_W = 8;
    localparam int LEN_BITS = 32;

    // decode phase of the current stream
    localparam logic [2:0] PH_FLAG = 3'd0;
    localparam logic [2:0] PH_PASS = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_TREE = 3'd3;
    localparam logic [2:0] PH_SKIP = 3'd4;
    localparam logic [2:0] PH_DATA = 3'd5;
    localparam logic [2:0] PH_DEAD = 3'd6;

    // node memory write select
    localparam logic [1:0] NM_WR_NONE  = 2'd0;
    localparam logic [1:0] NM_WR_LEFT  = 2'd1;
    localparam logic [1:0] NM_WR_RIGHT = 2'd2;
    localparam logic [1:0] NM_WR_INFO  = 2'd3;

    // leaf flag and symbol of one node
    typedef struct packed {
        logic             leaf;
        logic [SYM_W-1:0] sym;
    } node_info_t;

    // once the tree bits run out: a finished tree moves on, an open one is dead
    function automatic logic [2:0] tree_end(input logic [2:0] ph, input logic bits_done);
        logic [2:0] res;
        res = ph;
        if (bits_done)
        begin
            if (ph == PH_SKIP)
                res = PH_DATA;
            else if (ph == PH_TREE)
                res = PH_DEAD;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/huffman_stream_decoder.sv
// Top level: bit sequencer that reads the header, builds the tree and walks it.
// Uses hsd_pkg, hsd_node_mem and hsd_stack_mem.
//
//  channel  | signals                                   | dir | content
//  s_axis   | tvalid tready tdata[7:0] tlast            | in  | in_byte, stream_end
//  m_axis   | tvalid tready tdata[7:0] tlast            | out | out_symbol, run_last
//
// A byte is taken while idle; then the bits of the byte held before it are
// handled one at a time: length and skip bits in the bit state, tree bits via
// stack read, parent link and new node as needed, data bits via child read,
// node read and decide (bit state only with a single-leaf tree), then a flush.
// Reset clears the sequencer; the node and stack memories need no clearing.
// Output stalls hold the sequencer at its next symbol; tready is low while busy.
`default_nettype none

module huffman_stream_decoder #(
    parameter int TREE_NODES = 511,
    parameter int STACK_DEPTH = 256
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire        s_axis_tlast,   // stream_end
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_symbol
    output logic       m_axis_tlast    // run_last
);

    localparam int IDX_W = $clog2(TREE_NODES);
    localparam int NF_W  = $clog2(TREE_NODES + 1);
    localparam int SP_W  = $clog2(STACK_DEPTH);
    localparam int ST_W  = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BIT    = 3'd1;
    localparam logic [2:0] S_PARENT = 3'd2;
    localparam logic [2:0] S_NEW    = 3'd3;
    localparam logic [2:0] S_W1     = 3'd4;
    localparam logic [2:0] S_W2     = 3'd5;
    localparam logic [2:0] S_FLUSH  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [2:0]       phase_reg, phase_next;
    logic [31:0]      hbl_reg, hbl_next;
    logic [11:0]      lb_reg, lb_next;
    logic [ST_W-1:0]  top_reg, top_next;
    logic [NF_W-1:0]  nf_reg, nf_next;
    logic [IDX_W-1:0] walk_reg, walk_next;
    logic             held_valid_reg, held_valid_next;
    logic [7:0]       held_reg, held_next;
    logic [7:0]       shift_reg, shift_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic             end_reg, end_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic             b_reg, b_next;
    logic [IDX_W-1:0] child_reg, child_next;
    logic             root_leaf_reg, root_leaf_next;
    logic [7:0]       root_val_reg, root_val_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [7:0]       pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_sym_reg, out_sym_next;
    logic             out_last_reg, out_last_next;

    logic [1:0]          nm_wsel;
    logic [IDX_W-1:0]    nm_waddr, nm_wchild;
    hsd_pkg::node_info_t nm_winfo;
    logic                nm_ch_re, nm_info_re;
    logic [IDX_W-1:0]    nm_ch_raddr, nm_info_raddr;
    logic [IDX_W-1:0]    nm_left_q, nm_right_q;
    hsd_pkg::node_info_t nm_info_q;

    logic              st_we, st_re;
    logic [SP_W-1:0]   st_waddr, st_raddr;
    logic [IDX_W:0]    st_wdata, st_q;

    logic              accept, out_free, can_emit, emit_req, adv, bit_in;
    logic [7:0]        emit_sym;
    logic [ST_W-1:0]   top_m1;
    logic [NF_W-1:0]   nf_m1;
    logic [31:0]       hbl_dec;
    logic [3:0]        rem, nb;
    logic [7:0]        val;
    logic [2:0]        ph;
    logic [IDX_W-1:0]  child;
    logic              in_range;

    hsd_node_mem #(.TREE_NODES(TREE_NODES), .IDX_W(IDX_W)) u_nodes (
        .clk        (clk),
        .wsel       (nm_wsel),
        .waddr      (nm_waddr),
        .wchild     (nm_wchild),
        .winfo      (nm_winfo),
        .ch_re      (nm_ch_re),
        .ch_raddr   (nm_ch_raddr),
        .info_re    (nm_info_re),
        .info_raddr (nm_info_raddr),
        .left_q     (nm_left_q),
        .right_q    (nm_right_q),
        .info_q     (nm_info_q)
    );

    hsd_stack_mem #(.STACK_DEPTH(STACK_DEPTH), .SP_W(SP_W), .DATA_W(IDX_W + 1)) u_stack (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_q)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sym_reg;
    assign m_axis_tlast  = out_last_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign can_emit      = !pend_valid_reg || out_free;
    assign top_m1        = ST_W'(top_reg - ST_W'(1));
    assign nf_m1         = NF_W'(nf_reg - NF_W'(1));
    assign bit_in        = shift_reg[7];

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        hbl_next        = hbl_reg;
        lb_next         = lb_reg;
        top_next        = top_reg;
        nf_next         = nf_reg;
        walk_next       = walk_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        shift_next      = shift_reg;
        cnt_next        = cnt_reg;
        end_next        = end_reg;
        n_next          = n_reg;
        b_next          = b_reg;
        child_next      = child_reg;
        root_leaf_next  = root_leaf_reg;
        root_val_next   = root_val_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_sym_next    = out_sym_reg;
        out_last_next   = out_last_reg;

        nm_wsel       = hsd_pkg::NM_WR_NONE;
        nm_waddr      = n_reg;
        nm_wchild     = n_reg;
        nm_winfo      = '0;
        nm_ch_re      = 1'b0;
        nm_ch_raddr   = walk_reg;
        nm_info_re    = 1'b0;
        nm_info_raddr = child_reg;
        st_we         = 1'b0;
        st_waddr      = top_m1[SP_W-1:0];
        st_wdata      = '0;
        st_re         = 1'b0;
        st_raddr      = top_m1[SP_W-1:0];

        emit_req = 1'b0;
        emit_sym = '0;
        adv      = 1'b0;
        hbl_dec  = hbl_reg - 32'd1;
        rem      = lb_reg[11:8] - 4'd1;
        val      = {lb_reg[6:0], bit_in};
        nb       = (s_axis_tdata > 8'd8) ? 4'd8 : s_axis_tdata[3:0];
        ph       = phase_reg;
        child    = b_reg ? nm_right_q : nm_left_q;
        in_range = (32'(child_reg) < TREE_NODES);

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    end_next = s_axis_tlast;
                    if (phase_reg == hsd_pkg::PH_FLAG)
                    begin
                        if (!s_axis_tlast)
                            phase_next = s_axis_tdata[0] ? hsd_pkg::PH_PASS : hsd_pkg::PH_LEN;
                    end
                    else if (phase_reg == hsd_pkg::PH_PASS)
                    begin
                        pend_valid_next = 1'b1;
                        pend_next       = s_axis_tdata;
                        state_next      = S_FLUSH;
                    end
                    else if (s_axis_tlast)
                    begin
                        shift_next = held_reg;
                        cnt_next   = nb;
                        state_next = (held_valid_reg && nb != 4'd0) ? S_BIT : S_FLUSH;
                    end
                    else
                    begin
                        held_valid_next = 1'b1;
                        held_next       = s_axis_tdata;
                        shift_next      = held_reg;
                        cnt_next        = 4'd8;
                        if (held_valid_reg)
                            state_next = S_BIT;
                    end
                end
            end

            S_BIT:
            begin
                b_next = bit_in;
                priority case (phase_reg)
                    hsd_pkg::PH_LEN:
                    begin
                        hbl_next = {hbl_reg[30:0], bit_in};
                        if (lb_reg + 12'd1 >= 12'(hsd_pkg::LEN_BITS))
                        begin
                            lb_next    = '0;
                            phase_next = ({hbl_reg[30:0], bit_in} == 32'd0) ?
                                         hsd_pkg::PH_DEAD : hsd_pkg::PH_TREE;
                        end
                        else
                            lb_next = lb_reg + 12'd1;
                        adv = 1'b1;
                    end
                    hsd_pkg::PH_TREE:
                    begin
                        hbl_next = hbl_dec;
                        if (lb_reg[11:8] != 4'd0)
                        begin
                            // one value bit of the leaf under construction
                            lb_next = {rem, val};
                            if (rem == 4'd0)
                            begin
                                nm_wsel  = hsd_pkg::NM_WR_INFO;
                                nm_waddr = nf_m1[IDX_W-1:0];
                                nm_winfo = '{leaf: 1'b1, sym: val};
                                if (top_reg == '0)
                                    ph = hsd_pkg::PH_SKIP;
                            end
                            phase_next = hsd_pkg::tree_end(ph, hbl_dec == 32'd0);
                            adv = 1'b1;
                        end
                        else if (32'(nf_reg) >= TREE_NODES)
                        begin
                            phase_next = hsd_pkg::PH_DEAD;
                            adv = 1'b1;
                        end
                        else
                        begin
                            n_next  = nf_reg[IDX_W-1:0];
                            nf_next = NF_W'(nf_reg + NF_W'(1));
                            if (nf_reg == '0)
                                state_next = S_NEW;
                            else if (top_reg == '0)
                            begin
                                phase_next = hsd_pkg::PH_DEAD;
                                adv = 1'b1;
                            end
                            else
                            begin
                                st_re      = 1'b1;
                                state_next = S_PARENT;
                            end
                        end
                    end
                    hsd_pkg::PH_SKIP:
                    begin
                        hbl_next = hbl_dec;
                        if (hbl_dec == 32'd0)
                            phase_next = hsd_pkg::PH_DATA;
                        adv = 1'b1;
                    end
                    hsd_pkg::PH_DATA:
                    begin
                        if (root_leaf_reg)
                        begin
                            emit_req = 1'b1;
                            emit_sym = root_val_reg;
                            adv      = can_emit;
                        end
                        else
                        begin
                            nm_ch_re   = 1'b1;
                            state_next = S_W1;
                        end
                    end
                    default:
                        adv = 1'b1;
                endcase
            end

            S_PARENT:
            begin
                // link the new node under the open parent on top of the stack
                nm_waddr  = st_q[IDX_W-1:0];
                nm_wchild = n_reg;
                if (!st_q[IDX_W])
                begin
                    nm_wsel  = hsd_pkg::NM_WR_LEFT;
                    st_we    = 1'b1;
                    st_wdata = {1'b1, st_q[IDX_W-1:0]};
                end
                else
                begin
                    nm_wsel  = hsd_pkg::NM_WR_RIGHT;
                    top_next = top_m1;
                end
                state_next = S_NEW;
            end

            S_NEW:
            begin
                nm_waddr = n_reg;
                if (b_reg)
                begin
                    if (32'(top_reg) >= STACK_DEPTH)
                        ph = hsd_pkg::PH_DEAD;
                    else
                    begin
                        nm_wsel  = hsd_pkg::NM_WR_INFO;
                        nm_winfo = '{leaf: 1'b0, sym: 8'd0};
                        st_we    = 1'b1;
                        st_waddr = top_reg[SP_W-1:0];
                        st_wdata = {1'b0, n_reg};
                        top_next = ST_W'(top_reg + ST_W'(1));
                    end
                end
                else
                begin
                    nm_wsel  = hsd_pkg::NM_WR_INFO;
                    nm_winfo = '{leaf: 1'b1, sym: 8'd0};
                    lb_next  = {4'(hsd_pkg::SYM_W), 8'd0};
                end
                phase_next = hsd_pkg::tree_end(ph, hbl_reg == 32'd0);
                adv = 1'b1;
            end

            S_W1:
            begin
                child_next    = child;
                nm_info_re    = 1'b1;
                nm_info_raddr = child;
                state_next    = S_W2;
            end

            S_W2:
            begin
                if (in_range && nm_info_q.leaf)
                begin
                    emit_req = 1'b1;
                    emit_sym = nm_info_q.sym;
                    if (can_emit)
                    begin
                        walk_next = '0;
                        adv = 1'b1;
                    end
                end
                else
                begin
                    walk_next = in_range ? child_reg : '0;
                    adv = 1'b1;
                end
            end

            S_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_sym_next    = pend_reg;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                    if (end_reg)
                    begin
                        phase_next      = hsd_pkg::PH_FLAG;
                        hbl_next        = '0;
                        lb_next         = '0;
                        top_next        = '0;
                        nf_next         = '0;
                        walk_next       = '0;
                        held_valid_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase

        // one symbol is kept back so the last of the byte can carry tlast
        if (emit_req && can_emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_sym_next   = pend_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = emit_sym;
        end

        if (nm_wsel == hsd_pkg::NM_WR_INFO && nm_waddr == '0)
        begin
            root_leaf_next = nm_winfo.leaf;
            root_val_next  = nm_winfo.sym;
        end

        if (adv)
        begin
            shift_next = {shift_reg[6:0], 1'b0};
            cnt_next   = cnt_reg - 4'd1;
            state_next = (cnt_reg == 4'd1) ? S_FLUSH : S_BIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= hsd_pkg::PH_FLAG;
            hbl_reg        <= '0;
            lb_reg         <= '0;
            top_reg        <= '0;
            nf_reg         <= '0;
            walk_reg       <= '0;
            held_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            hbl_reg        <= hbl_next;
            lb_reg         <= lb_next;
            top_reg        <= top_next;
            nf_reg         <= nf_next;
            walk_reg       <= walk_next;
            held_valid_reg <= held_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg      <= held_next;
        shift_reg     <= shift_next;
        cnt_reg       <= cnt_next;
        end_reg       <= end_next;
        n_reg         <= n_next;
        b_reg         <= b_next;
        child_reg     <= child_next;
        root_leaf_reg <= root_leaf_next;
        root_val_reg  <= root_val_next;
        pend_reg      <= pend_next;
        out_sym_reg   <= out_sym_next;
        out_last_reg  <= out_last_next;
    end

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("symbol left pending while idle");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(top_reg) <= STACK_DEPTH)
        else $error("stack pointer past depth");

    a_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(nf_reg) <= TREE_NODES)
        else $error("node count past capacity");

    a_pass_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == hsd_pkg::PH_PASS |=> pend_valid_reg && state_reg == S_FLUSH)
        else $error("pass-through transaction not queued");

endmodule

`default_nettype wire

### rtl/hsd_node_mem.sv
// Tree node storage: leaf/symbol, left child and right child arrays.
// One write per cycle, registered reads. Uses hsd_pkg.
`default_nettype none

module hsd_node_mem #(
    parameter int TREE_NODES = 511,
    parameter int IDX_W = 9
) (
    input  wire                      clk,
    input  wire  [1:0]               wsel,
    input  wire  [IDX_W-1:0]         waddr,
    input  wire  [IDX_W-1:0]         wchild,
    input  hsd_pkg::node_info_t      winfo,
    input  wire                      ch_re,
    input  wire  [IDX_W-1:0]         ch_raddr,
    input  wire                      info_re,
    input  wire  [IDX_W-1:0]         info_raddr,
    output logic [IDX_W-1:0]         left_q,
    output logic [IDX_W-1:0]         right_q,
    output hsd_pkg::node_info_t      info_q
);

    logic [IDX_W-1:0]    left_mem  [TREE_NODES];
    logic [IDX_W-1:0]    right_mem [TREE_NODES];
    hsd_pkg::node_info_t info_mem  [TREE_NODES];

    always_ff @(posedge clk)
    begin
        unique case (wsel)
            hsd_pkg::NM_WR_LEFT:  left_mem[waddr]  <= wchild;
            hsd_pkg::NM_WR_RIGHT: right_mem[waddr] <= wchild;
            hsd_pkg::NM_WR_INFO:  info_mem[waddr]  <= winfo;
            default: ;
        endcase
        if (ch_re)
        begin
            left_q  <= left_mem[ch_raddr];
            right_q <= right_mem[ch_raddr];
        end
        if (info_re)
            info_q <= info_mem[info_raddr];
    end

endmodule

`default_nettype wire

### rtl/hsd_stack_mem.sv
// Build stack storage: open parent index plus next child side.
// One write and one registered read per cycle. No dependencies.
`default_nettype none

module hsd_stack_mem #(
    parameter int STACK_DEPTH = 256,
    parameter int SP_W = 8,
    parameter int DATA_W = 10
) (
    input  wire               clk,
    input  wire               we,
    input  wire  [SP_W-1:0]   waddr,
    input  wire  [DATA_W-1:0] wdata,
    input  wire               re,
    input  wire  [SP_W-1:0]   raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [STACK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### verif/tb_huffman_stream_decoder.sv
// Self-checking testbench for huffman_stream_decoder: drives compressed streams
// (pass-through, well-formed trees, dead and exhausted streams, noise) and checks
// every decoded symbol against a cycle-free predictor. Depends on hsd_pkg and the RTL.
`default_nettype none

module tb_huffman_stream_decoder;

    // small node and stack capacity so exhaustion is reached in a few dozen bytes
    localparam int NODE_CNT  = 63;
    localparam int STACK_CNT = 16;
    localparam int CYC_LIMIT = 600000;
    localparam int FLUSH_CYC = 64;

    typedef struct {
        logic [7:0] sym;
        logic       last;
    } sym_t;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    huffman_stream_decoder #(.TREE_NODES(NODE_CNT), .STACK_DEPTH(STACK_CNT)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // decoder model state
    logic [26:0] node_mem [NODE_CNT];
    logic [9:0]  stack_mem [STACK_CNT];
    logic [2:0]  phase;
    logic [31:0] hdr_bits;
    int unsigned stk_top;
    int unsigned free_node;
    logic [11:0] leaf_acc;
    int unsigned walk_idx;
    logic [8:0]  held;

    sym_t        pending_syms[$];
    logic [7:0]  step_syms[$];
    bit          bit_q[$];

    int          n_errors;
    int          n_sent;
    int          n_checked;
    int          n_streams;
    int          cycles;
    int          burst_left;
    int          stall_mode;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (stall_mode == 0)
            m_axis_tready <= 1'b1;
        else if (stall_mode == 1)
            m_axis_tready <= ((cycles % 13) >= 4);
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // output checker; values are stable at negedge and taken at the next posedge
    always @(negedge clk)
    begin
        sym_t exp_sym;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_syms.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected transaction sym=%02h last=%0b", $time,
                         m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                exp_sym = pending_syms.pop_front();
                n_checked++;
                if (m_axis_tdata !== exp_sym.sym || m_axis_tlast !== exp_sym.last)
                begin
                    n_errors++;
                    $display("%0t: mismatch expected sym=%02h last=%0b actual sym=%02h last=%0b",
                             $time, exp_sym.sym, exp_sym.last, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    function automatic logic [26:0] node_at(int unsigned idx);
        return (idx < NODE_CNT) ? node_mem[idx] : 27'd0;
    endfunction

    function automatic void clear_stream();
        phase = hsd_pkg::PH_FLAG;
        hdr_bits = '0;
        stk_top = 0;
        free_node = 0;
        leaf_acc = '0;
        walk_idx = 0;
        held = '0;
    endfunction

    function automatic void build_bit(bit b);
        int unsigned remaining;
        int unsigned n;
        int unsigned p;
        logic [7:0]  val;
        logic [9:0]  e;
        remaining = leaf_acc[11:8];
        if (remaining != 0)
        begin
            val = {leaf_acc[6:0], b};
            n = (free_node - 1) & 9'h1FF;
            remaining--;
            leaf_acc = {remaining[3:0], val};
            if (remaining == 0 && n < NODE_CNT)
            begin
                node_mem[n] = {1'b1, val, 18'd0};
                if (stk_top == 0)
                    phase = hsd_pkg::PH_SKIP;
            end
            return;
        end
        if (free_node >= NODE_CNT)
        begin
            phase = hsd_pkg::PH_DEAD;
            return;
        end
        n = free_node;
        free_node++;
        if (n != 0)
        begin
            if (stk_top == 0 || stk_top > STACK_CNT)
            begin
                phase = hsd_pkg::PH_DEAD;
                return;
            end
            e = stack_mem[stk_top - 1];
            p = e[8:0];
            if (p < NODE_CNT)
            begin
                if (!e[9])
                begin
                    node_mem[p][17:9] = n[8:0];
                    stack_mem[stk_top - 1] = {1'b1, e[8:0]};
                end
                else
                begin
                    node_mem[p][8:0] = n[8:0];
                    stk_top--;
                end
            end
        end
        if (b)
        begin
            if (stk_top >= STACK_CNT)
            begin
                phase = hsd_pkg::PH_DEAD;
                return;
            end
            node_mem[n] = '0;
            stack_mem[stk_top] = {1'b0, n[8:0]};
            stk_top++;
        end
        else
        begin
            node_mem[n] = {1'b1, 26'd0};
            leaf_acc = {4'd8, 8'd0};
        end
    endfunction

    function automatic void decode_bit(bit b);
        logic [26:0] root;
        logic [26:0] cur;
        logic [26:0] cn;
        int unsigned child;
        case (phase)
            hsd_pkg::PH_LEN:
            begin
                hdr_bits = {hdr_bits[30:0], b};
                leaf_acc++;
                if (leaf_acc >= hsd_pkg::LEN_BITS)
                begin
                    leaf_acc = '0;
                    phase = (hdr_bits == 0) ? hsd_pkg::PH_DEAD : hsd_pkg::PH_TREE;
                end
            end
            hsd_pkg::PH_TREE:
            begin
                hdr_bits--;
                build_bit(b);
                if (hdr_bits == 0)
                begin
                    if (phase == hsd_pkg::PH_SKIP)
                        phase = hsd_pkg::PH_DATA;
                    else if (phase == hsd_pkg::PH_TREE)
                        phase = hsd_pkg::PH_DEAD;
                end
            end
            hsd_pkg::PH_SKIP:
            begin
                hdr_bits--;
                if (hdr_bits == 0)
                    phase = hsd_pkg::PH_DATA;
            end
            hsd_pkg::PH_DATA:
            begin
                root = node_at(0);
                if (root[26])
                    step_syms = {step_syms, root[25:18]};
                else
                begin
                    cur = node_at(walk_idx);
                    child = b ? cur[8:0] : cur[17:9];
                    cn = node_at(child);
                    if (cn[26])
                    begin
                        step_syms = {step_syms, cn[25:18]};
                        walk_idx = 0;
                    end
                    else
                        walk_idx = (child < NODE_CNT) ? child : 0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void decode_held(int unsigned nbits);
        if (!held[8])
            return;
        for (int i = 0; i < nbits && i < 8; i++)
            decode_bit(held[7 - i]);
    endfunction

    // expected symbols for one accepted input transaction
    function automatic void predict_byte(logic [7:0] b, logic fin);
        sym_t s;
        step_syms.delete();
        if (phase == hsd_pkg::PH_FLAG)
        begin
            if (!fin)
                phase = b[0] ? hsd_pkg::PH_PASS : hsd_pkg::PH_LEN;
            else
                clear_stream();
        end
        else if (phase == hsd_pkg::PH_PASS)
        begin
            step_syms = {step_syms, b};
            if (fin)
                clear_stream();
        end
        else if (fin)
        begin
            decode_held((b > 8) ? 8 : b);
            clear_stream();
        end
        else
        begin
            decode_held(8);
            held = {1'b1, b};
        end
        foreach (step_syms[i])
        begin
            s.sym = step_syms[i];
            s.last = (i == step_syms.size() - 1);
            pending_syms = {pending_syms, s};
        end
    endfunction

    task automatic send_byte(logic [7:0] b, logic fin);
        int  gap;
        bit  ok;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= fin;
        do
        begin
            @(negedge clk);
            ok = s_axis_tready;
            @(posedge clk);
        end
        while (!ok);
        predict_byte(b, fin);
        n_sent++;
    endtask

    function automatic void put_bits(logic [31:0] v, int n);
        for (int i = n - 1; i >= 0; i--)
            bit_q = {bit_q, v[i]};
    endfunction

    function automatic void put_rand_bits(int n);
        bit r;
        for (int i = 0; i < n; i++)
        begin
            r = 1'($urandom_range(0, 1));
            bit_q = {bit_q, r};
        end
    endfunction

    // random full binary tree in preorder, with at most max_leaves leaves
    function automatic void put_tree(ref bit tq[$], input int max_leaves);
        int open;
        int leaves;
        logic [7:0] v;
        open = 1;
        leaves = 0;
        while (open > 0)
        begin
            if (leaves + open < max_leaves && $urandom_range(0, 1))
            begin
                tq = {tq, 1'b1};
                open++;
            end
            else
            begin
                v = 8'($urandom);
                tq = {tq, 1'b0};
                for (int i = 7; i >= 0; i--)
                    tq = {tq, v[i]};
                open--;
                leaves++;
            end
        end
    endfunction

    // flag byte, packed bit_q, end byte; end_len < 0 gives the exact valid count
    task automatic send_stream(bit pass, int end_len);
        logic [7:0] b;
        int         rem;
        b = 8'($urandom);
        b[0] = pass;
        send_byte(b, 1'b0);
        rem = bit_q.size() % 8;
        while (bit_q.size() > 0)
        begin
            b = '0;
            for (int i = 7; i >= 0; i--)
                if (bit_q.size() > 0)
                    b[i] = bit_q.pop_front();
                else
                    b[i] = 1'($urandom_range(0, 1));
            send_byte(b, 1'b0);
        end
        if (end_len < 0)
            send_byte((rem == 0) ? 8'd8 : rem[7:0], 1'b1);
        else
            send_byte(end_len[7:0], 1'b1);
        n_streams++;
    endtask

    task automatic tree_stream(int max_leaves, int extra, int data_bits, int end_len);
        bit tq[$];
        put_tree(tq, max_leaves);
        put_bits(tq.size() + extra, hsd_pkg::LEN_BITS);
        foreach (tq[i])
            bit_q = {bit_q, tq[i]};
        put_rand_bits(extra + data_bits);
        send_stream(1'b0, end_len);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_syms.size() > 0)
            @(posedge clk);
        repeat (FLUSH_CYC) @(posedge clk);
    endtask

    task automatic test_stream_edges();
        send_byte(8'h00, 1'b1);          // end on the flag byte
        send_byte(8'hFE, 1'b0);          // end with nothing held
        send_byte(8'h05, 1'b1);
    endtask

    task automatic test_passthrough();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);          // final byte is emitted too
    endtask

    task automatic test_single_leaf();
        put_bits(9, hsd_pkg::LEN_BITS);
        put_bits(9'h0FF, 9);             // leaf 0xFF
        put_rand_bits(11);
        send_stream(1'b0, -1);
    endtask

    task automatic test_small_tree();
        tree_stream(3, 5, 16, 200);      // spare tree bits, count above eight
    endtask

    task automatic test_dead_streams();
        put_bits(0, hsd_pkg::LEN_BITS);  // zero length
        put_rand_bits(16);
        send_stream(1'b0, -1);
        put_bits(3, hsd_pkg::LEN_BITS);  // length ends before tree completes
        put_bits(3'b110, 3);
        put_rand_bits(20);
        send_stream(1'b0, -1);
    endtask

    task automatic test_exhaustion();
        stall_mode = 0;
        put_bits(40, hsd_pkg::LEN_BITS); // too many open internal nodes
        put_bits('1, 20);
        put_bits(1, 1);
        put_rand_bits(30);
        send_stream(1'b0, -1);
        put_bits(400, hsd_pkg::LEN_BITS); // more nodes than the memory holds
        for (int i = 0; i < (NODE_CNT + 1) / 2; i++)
        begin
            put_bits(2'b10, 2);
            put_rand_bits(8);
        end
        put_rand_bits(40);
        send_stream(1'b0, -1);
        wait_drained();
    endtask

    task automatic test_random(int target);
        int kind;
        int k;
        while (n_sent < target)
        begin
            kind = $urandom_range(0, 99);
            stall_mode = $urandom_range(0, 2);
            if (kind < 65)
                tree_stream($urandom_range(2, 12), $urandom_range(0, 1) ? 0 : $urandom_range(1, 9),
                            $urandom_range(4, 64), ($urandom_range(0, 4) == 0) ? $urandom : -1);
            else if (kind < 75)
            begin
                put_rand_bits(8 * $urandom_range(1, 6));
                send_stream(1'b1, $urandom);
            end
            else if (kind < 87)
            begin
                k = $urandom_range(1, 8);
                for (int i = 0; i < k; i++)
                    send_byte(8'($urandom), 1'b0);
                send_byte(8'($urandom), 1'b1);
            end
            else
            begin
                put_bits($urandom_range(1, 12), hsd_pkg::LEN_BITS);
                put_rand_bits($urandom_range(4, 40));
                send_stream(1'b0, $urandom_range(0, 12));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        n_errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_streams = 0;
        cycles = 0;
        burst_left = 0;
        stall_mode = 0;
        for (int i = 0; i < NODE_CNT; i++)
            node_mem[i] = '0;
        for (int i = 0; i < STACK_CNT; i++)
            stack_mem[i] = '0;
        clear_stream();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_stream_edges();
        test_passthrough();
        stall_mode = 2;
        test_single_leaf();
        test_small_tree();
        test_dead_streams();
        wait_drained();
        test_exhaustion();
        test_random(n_sent + 200);
        wait_drained();

        $display("Sent %0d bytes in %0d streams, checked %0d decoded symbols.",
                 n_sent, n_streams, n_checked);
        $display("Covered pass-through, single leaf, dead and exhausted trees, noise.");
        if (n_errors == 0 && pending_syms.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/hsd_pkg.sv
rtl/hsd_node_mem.sv
rtl/hsd_stack_mem.sv
rtl/huffman_stream_decoder.sv
verif/tb_huffman_stream_decoder.sv
